// ----- hdl/pcx_pkg.sv -----
// Shared widths, codes and transfer types for the PCX run-length image decoder.
package pcx_pkg;

   localparam int COL_W  = 10;
   localparam int ROW_W  = 9;
   localparam int PAL_W  = 10;
   localparam int CNT_W  = 6;
   localparam int BYTE_W = 8;
   localparam int CSR_W  = 10;

   localparam int MAX_WIDTH     = 640;
   localparam int MAX_HEIGHT    = 480;
   localparam int PALETTE_BYTES = 768;

   localparam logic [BYTE_W-1:0] RUN_TAG        = 8'hC0;
   localparam logic [BYTE_W-1:0] PALETTE_MARKER = 8'h0C;

   localparam logic KIND_PIXEL   = 1'b0;
   localparam logic KIND_PALETTE = 1'b1;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 2;
   localparam int USER_KIND  = 0;
   localparam int USER_DONE  = 1;

   typedef struct packed {
      logic             kind;
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic [PAL_W-1:0] pal_pos;
      logic [CNT_W-1:0] count;
      logic [COL_W-1:0] width;
      logic [ROW_W-1:0] height;
   } step_in_type;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic [PAL_W-1:0] pal_pos;
      logic [CNT_W-1:0] count;
      logic [COL_W-1:0] out_column;
      logic [ROW_W-1:0] out_row;
      logic [PAL_W-1:0] out_pal;
      logic             done;
      logic             last;
   } step_out_type;

endpackage

// ----- hdl/pcx_step_unit.sv -----
// Shared position step: one increment and limit compare for pixel columns and palette bytes.
module pcx_step_unit (
   input  pcx_pkg::step_in_type  step_in,
   output pcx_pkg::step_out_type step_out
);
   import pcx_pkg::*;

   logic [COL_W:0] operand;
   logic [COL_W:0] limit;
   logic [COL_W:0] inc;
   logic           wrap;
   logic [ROW_W:0] row_inc;
   logic           row_end;

   assign operand = (step_in.kind == KIND_PALETTE) ? {1'b0, step_in.pal_pos}
                                                   : {1'b0, step_in.column};
   assign limit   = (step_in.kind == KIND_PALETTE) ? (COL_W+1)'(PALETTE_BYTES)
                                                   : {1'b0, step_in.width};
   assign inc     = operand + (COL_W+1)'(1);
   assign wrap    = (inc >= limit);
   assign row_inc = {1'b0, step_in.row} + (ROW_W+1)'(1);
   assign row_end = (row_inc >= {1'b0, step_in.height});

   always_comb begin
      step_out = '0;
      step_out.column  = step_in.column;
      step_out.row     = step_in.row;
      step_out.pal_pos = step_in.pal_pos;
      if (step_in.kind == KIND_PALETTE) begin
         step_out.pal_pos = inc[PAL_W-1:0];
         step_out.out_pal = step_in.pal_pos;
         step_out.count   = '0;
         step_out.done    = wrap;
      end else begin
         step_out.out_column = step_in.column;
         step_out.out_row    = step_in.row;
         if (wrap) begin
            step_out.column = '0;
            step_out.row    = row_inc[ROW_W-1:0];
            step_out.count  = '0;
            step_out.done   = row_end;
         end else begin
            step_out.column = inc[COL_W-1:0];
            step_out.count  = step_in.count - CNT_W'(1);
            step_out.done   = 1'b0;
         end
      end
      step_out.last = (step_out.count == '0);
   end

endmodule

// ----- hdl/pcx_rle_image_decoder.sv -----
// Top level of the PCX 8-bit run-length image body decoder.
//
// Feed the compressed image body one byte per req transaction: req_tdata holds
// the byte, req_tuser marks the first byte of an image and clears the decoder
// before that byte is handled. Each pixel or palette byte leaves as one rsp
// transaction; rsp_tlast marks the last result caused by one input byte.
// Set image width and height through the csr write port while idle.
//
// A literal pixel or palette byte is first taken into the work registers, then
// the shared step unit produces its result. A run byte only records the count,
// and the byte after it gives one result per pixel (up to 63, or to the row end).
// The step unit produces at most one result per cycle while the rsp side accepts,
// and is the limit on throughput. Run tags, markers and bytes after the end give no result.
// req_tready is low while a run or byte is being expanded.
// A stalled rsp side holds the output register and freezes the expansion.
// Synchronous reset clears the control state and rsp valid and sets width and height to one.
module pcx_rle_image_decoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pcx_pkg::BYTE_W-1:0]        req_tdata,  // [7:0] data_byte
   input  logic                              req_tuser,  // [0] start_of_image
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pcx_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // value, column, row, palette_index
   output logic [pcx_pkg::RSP_USER_W-1:0]    rsp_tuser,  // item_kind, image_done
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [pcx_pkg::CSR_W-1:0]         csr_wdata
);
   import pcx_pkg::*;

   localparam logic [1:0] PH_PIXELS  = 2'd0;
   localparam logic [1:0] PH_MARKER  = 2'd1;
   localparam logic [1:0] PH_PALETTE = 2'd2;
   localparam logic [1:0] PH_DONE    = 2'd3;

   logic [COL_W-1:0]  width_ff, width_in;
   logic [ROW_W-1:0]  height_ff, height_in;
   logic [1:0]        phase_ff, phase_in;
   logic              run_pending_ff, run_pending_in;
   logic [CNT_W-1:0]  run_count_ff, run_count_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [PAL_W-1:0]  pal_ff, pal_in;
   logic              busy_ff, busy_in;
   logic              work_kind_ff, work_kind_in;
   logic [BYTE_W-1:0] work_val_ff, work_val_in;
   logic [CNT_W-1:0]  work_cnt_ff, work_cnt_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic         req_fire;
   logic         emit_fire;
   logic [1:0]   phase_eff;
   logic         pending_eff;
   logic [CNT_W-1:0] count_eff;
   step_in_type  step_in;
   step_out_type step_out;

   assign req_tready = !busy_ff;
   assign req_fire   = req_tvalid && !busy_ff;
   assign emit_fire  = busy_ff && (!rsp_valid_ff || rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign step_in.kind    = work_kind_ff;
   assign step_in.column  = col_ff;
   assign step_in.row     = row_ff;
   assign step_in.pal_pos = pal_ff;
   assign step_in.count   = work_cnt_ff;
   assign step_in.width   = width_ff;
   assign step_in.height  = height_ff;

   pcx_step_unit u_step (
      .step_in  (step_in),
      .step_out (step_out)
   );

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               if (csr_wdata == '0) begin
                  width_in = COL_W'(1);
               end else if (csr_wdata > CSR_W'(MAX_WIDTH)) begin
                  width_in = COL_W'(MAX_WIDTH);
               end else begin
                  width_in = csr_wdata[COL_W-1:0];
               end
            end
            CSR_IMAGE_HEIGHT: begin
               if (csr_wdata[ROW_W-1:0] == '0) begin
                  height_in = ROW_W'(1);
               end else if (csr_wdata[ROW_W-1:0] > ROW_W'(MAX_HEIGHT)) begin
                  height_in = ROW_W'(MAX_HEIGHT);
               end else begin
                  height_in = csr_wdata[ROW_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      run_pending_in = run_pending_ff;
      run_count_in   = run_count_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      pal_in         = pal_ff;
      busy_in        = busy_ff;
      work_kind_in   = work_kind_ff;
      work_val_in    = work_val_ff;
      work_cnt_in    = work_cnt_ff;
      phase_eff      = phase_ff;
      pending_eff    = run_pending_ff;
      count_eff      = run_count_ff;

      if (req_fire) begin
         if (req_tuser) begin
            phase_eff      = PH_PIXELS;
            pending_eff    = 1'b0;
            count_eff      = '0;
            phase_in       = PH_PIXELS;
            run_pending_in = 1'b0;
            run_count_in   = '0;
            col_in         = '0;
            row_in         = '0;
            pal_in         = '0;
         end
         work_val_in = req_tdata;
         unique case (phase_eff)
            PH_PIXELS: begin
               work_kind_in = KIND_PIXEL;
               if (pending_eff) begin
                  run_pending_in = 1'b0;
                  work_cnt_in    = count_eff;
                  busy_in        = (count_eff != '0);
               end else if ((req_tdata & RUN_TAG) == RUN_TAG) begin
                  run_pending_in = 1'b1;
                  run_count_in   = req_tdata[CNT_W-1:0];
               end else begin
                  work_cnt_in = CNT_W'(1);
                  busy_in     = 1'b1;
               end
            end
            PH_MARKER: begin
               if (req_tdata == PALETTE_MARKER) begin
                  phase_in = PH_PALETTE;
                  pal_in   = '0;
               end else begin
                  phase_in = PH_DONE;
               end
            end
            PH_PALETTE: begin
               work_kind_in = KIND_PALETTE;
               work_cnt_in  = CNT_W'(1);
               busy_in      = 1'b1;
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase
      end else if (emit_fire) begin
         col_in      = step_out.column;
         row_in      = step_out.row;
         pal_in      = step_out.pal_pos;
         work_cnt_in = step_out.count;
         busy_in     = !step_out.last;
         if (step_out.done) begin
            phase_in = (work_kind_ff == KIND_PALETTE) ? PH_DONE : PH_MARKER;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({step_out.out_pal, step_out.out_row,
                                     step_out.out_column, work_val_ff});
         rsp_user_in  = {step_out.done, work_kind_ff};
         rsp_last_in  = step_out.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= COL_W'(1);
         height_ff      <= ROW_W'(1);
         phase_ff       <= PH_PIXELS;
         run_pending_ff <= 1'b0;
         run_count_ff   <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
         pal_ff         <= '0;
         busy_ff        <= 1'b0;
         work_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         width_ff       <= width_in;
         height_ff      <= height_in;
         phase_ff       <= phase_in;
         run_pending_ff <= run_pending_in;
         run_count_ff   <= run_count_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         pal_ff         <= pal_in;
         busy_ff        <= busy_in;
         work_cnt_ff    <= work_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_kind_ff <= work_kind_in;
      work_val_ff  <= work_val_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
      rsp_last_ff  <= rsp_last_in;
   end

   a_pending_only_in_pixels: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_PIXELS) |-> !run_pending_ff)
      else $error("run pending outside pixel phase");

   a_busy_has_work: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (work_cnt_ff != '0))
      else $error("expansion active with zero count");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff[USER_DONE]) |-> rsp_last_ff)
      else $error("image end result not last of its byte");

   a_last_frees_input: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && step_out.last) |=> !busy_ff)
      else $error("expansion did not end after last result");

endmodule

// ----- test/pcx_rle_image_decoder_test.sv -----
// Self-checking testbench for the PCX run-length image decoder: directed and random byte streams.
module pcx_rle_image_decoder_test;

   import pcx_pkg::*;

   localparam int CLK_HALF     = 5;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 1_000_000;

   typedef enum logic [1:0] {PH_PIXELS, PH_MARKER, PH_PALETTE, PH_DONE} decode_phase_type;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] value;
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  row;
      logic [PAL_W-1:0]  pal_pos;
      logic              last;
      logic              done;
   } decoded_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic                  csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_W-1:0]      csr_wdata = '0;

   decoded_item_type decoded_items[$];

   decode_phase_type dec_phase;
   logic             dec_run_pending;
   int unsigned      dec_run_len;
   int unsigned      dec_col;
   int unsigned      dec_row;
   int unsigned      dec_pal_pos;
   int unsigned      cfg_width;
   int unsigned      cfg_height;

   int unsigned send_idle_pct;
   int unsigned rsp_stall_pct;
   int unsigned cycle_count;
   int unsigned fail_count;
   int unsigned bytes_sent;
   int unsigned pixels_seen;
   int unsigned palette_seen;

   pcx_rle_image_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] data_byte
      .req_tuser  (req_tuser),   // [0] start_of_image
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [7:0] value, [17:8] column, [26:18] row, [36:27] palette_index
      .rsp_tuser  (rsp_tuser),   // [0] item_kind, [1] image_done
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("pcx_rle_image_decoder regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
   endfunction

   function automatic void restart_image();
      dec_phase       = PH_PIXELS;
      dec_run_pending = 1'b0;
      dec_run_len     = 0;
      dec_col         = 0;
      dec_row         = 0;
      dec_pal_pos     = 0;
   endfunction

   function automatic void emit_pixel_run(logic [BYTE_W-1:0] value, int unsigned count);
      int unsigned      w;
      int unsigned      h;
      decoded_item_type item;
      w = clamp_dim(cfg_width, MAX_WIDTH);
      h = clamp_dim(cfg_height, MAX_HEIGHT);
      while (count > 0 && dec_phase == PH_PIXELS) begin
         item.kind    = KIND_PIXEL;
         item.value   = value;
         item.column  = dec_col[COL_W-1:0];
         item.row     = dec_row[ROW_W-1:0];
         item.pal_pos = '0;
         item.last    = 1'b0;
         item.done    = 1'b0;
         count--;
         dec_col++;
         if (dec_col >= w) begin
            dec_col = 0;
            dec_row++;
            count = 0;
            if (dec_row >= h) begin
               item.done = 1'b1;
               dec_phase = PH_MARKER;
            end
         end
         decoded_items.push_back(item);
      end
   endfunction

   function automatic void decode_byte(logic [BYTE_W-1:0] b, logic sof);
      int unsigned      first;
      decoded_item_type item;
      first = decoded_items.size();
      if (sof) restart_image();
      case (dec_phase)
         PH_PIXELS: begin
            if (dec_run_pending) begin
               dec_run_pending = 1'b0;
               emit_pixel_run(b, dec_run_len);
            end else if ((b & RUN_TAG) == RUN_TAG) begin
               dec_run_pending = 1'b1;
               dec_run_len     = 32'(b[CNT_W-1:0]);
            end else begin
               emit_pixel_run(b, 1);
            end
         end
         PH_MARKER: begin
            dec_phase   = (b == PALETTE_MARKER) ? PH_PALETTE : PH_DONE;
            dec_pal_pos = 0;
         end
         PH_PALETTE: begin
            item.kind    = KIND_PALETTE;
            item.value   = b;
            item.column  = '0;
            item.row     = '0;
            item.pal_pos = dec_pal_pos[PAL_W-1:0];
            item.last    = 1'b0;
            item.done    = 1'b0;
            dec_pal_pos++;
            if (dec_pal_pos >= PALETTE_BYTES) begin
               item.done = 1'b1;
               dec_phase = PH_DONE;
            end
            decoded_items.push_back(item);
         end
         default: ;
      endcase
      if (decoded_items.size() > first) begin
         item      = decoded_items.pop_back();
         item.last = 1'b1;
         decoded_items.push_back(item);
      end
   endfunction

   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic sof);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= sof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_byte(b, sof);
      bytes_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (decoded_items.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_dims(input logic [CSR_W-1:0] w, input logic [CSR_W-1:0] h);
      csr_we    <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we     <= 1'b0;
      cfg_width  = 32'(w);
      cfg_height = 32'(h[ROW_W-1:0]);
   endtask

   task automatic set_pressure(input int unsigned send_pct, input int unsigned stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   task automatic check_field(input string name, input logic [15:0] want_v,
                              input logic [15:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      decoded_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (decoded_items.size() == 0) begin
            $error("unexpected result transaction: tdata 0x%0h tuser 0x%0h",
                   rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            want = decoded_items.pop_front();
            check_field("item_kind", 16'(want.kind), 16'(rsp_tuser[USER_KIND]));
            check_field("value", 16'(want.value), 16'(rsp_tdata[7:0]));
            check_field("column", 16'(want.column), 16'(rsp_tdata[17:8]));
            check_field("row", 16'(want.row), 16'(rsp_tdata[26:18]));
            check_field("palette_index", 16'(want.pal_pos), 16'(rsp_tdata[36:27]));
            check_field("last_of_run", 16'(want.last), 16'(rsp_tlast));
            check_field("image_done", 16'(want.done), 16'(rsp_tuser[USER_DONE]));
            check_field("tdata padding", 16'd0, 16'(rsp_tdata[RSP_DATA_W-1:37]));
            if (want.kind == KIND_PIXEL) pixels_seen++;
            else palette_seen++;
         end
      end
   end

   // 1x1 image straight out of reset, palette entry, then a new image from a clipped run and ignored bytes
   task automatic test_power_on_dims();
      set_pressure(0, 0);
      push_byte(8'h41, 1'b1);
      push_byte(PALETTE_MARKER, 1'b0);
      push_byte(8'hFE, 1'b0);
      push_byte(8'hC4, 1'b1);
      push_byte(8'h07, 1'b0);
      push_byte(8'h33, 1'b0);
      push_byte(8'hC2, 1'b0);
      drain_results();
   endtask

   task automatic test_directed_bytes();
      write_dims(10'd4, 10'd3);
      push_byte(8'h00, 1'b1);
      push_byte(8'hBF, 1'b0);
      push_byte(8'h3F, 1'b0);
      push_byte(8'hC0, 1'b0);
      push_byte(8'h55, 1'b0);
      push_byte(8'hC2, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hAA, 1'b0);
      // hold off the sender until the block is empty, mid-image
      drain_results();
      push_byte(8'h80, 1'b0);
      push_byte(8'hC5, 1'b0);
      push_byte(8'h12, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(PALETTE_MARKER, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hC1, 1'b1);
      push_byte(8'h9C, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h77, 1'b0);
      push_byte(8'h0D, 1'b0);
      push_byte(PALETTE_MARKER, 1'b0);
      push_byte(8'hC3, 1'b0);
      drain_results();
   endtask

   task automatic test_dim_clamping();
      write_dims(10'd0, 10'd0);
      push_byte(8'h10, 1'b1);
      push_byte(8'hC3, 1'b0);
      push_byte(8'hFF, 1'b0);
      drain_results();
      write_dims(10'd1023, 10'd511);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h33, 1'b0);
      push_byte(8'hC0, 1'b0);
      push_byte(8'hFE, 1'b0);
      drain_results();
   endtask

   // one 640-pixel row from long runs with a short palette, then a narrow tall image
   task automatic test_full_frame();
      logic [CNT_W-1:0] len;
      int unsigned      pal_left;
      set_pressure(0, 61);
      write_dims(10'd1023, 10'd1);
      push_byte(8'hFF, 1'b1);
      push_byte(8'($urandom_range(255)), 1'b0);
      while (dec_phase == PH_PIXELS) begin
         if (dec_run_pending || $urandom_range(7) == 0) begin
            push_byte(8'($urandom_range(255)), 1'b0);
         end else begin
            len = 6'($urandom_range(32, 63));
            push_byte(RUN_TAG | {2'b00, len}, 1'b0);
         end
      end
      push_byte(PALETTE_MARKER, 1'b0);
      pal_left = 12;
      while (pal_left != 0) begin
         push_byte(8'($urandom_range(255)), 1'b0);
         pal_left--;
      end
      push_byte(8'h5A, 1'b1);
      drain_results();

      set_pressure(61, 0);
      write_dims(10'd1, {1'b1, 9'd24});
      push_byte(8'($urandom_range(191)), 1'b1);
      while (dec_phase == PH_PIXELS) begin
         if (!dec_run_pending && $urandom_range(1) == 0) begin
            len = 6'($urandom_range(63));
            push_byte(RUN_TAG | {2'b00, len}, 1'b0);
         end else begin
            push_byte(8'($urandom_range(255)), 1'b0);
         end
      end
      push_byte(8'hC0, 1'b0);
      drain_results();
   endtask

   task automatic random_stream(input int unsigned n_items);
      int unsigned      counted;
      int unsigned      roll;
      logic [BYTE_W-1:0] b;
      logic [CNT_W-1:0] len;
      logic             sof;
      counted = 0;
      while (counted < n_items) begin
         roll = $urandom_range(99);
         sof  = (roll < 3);
         b    = 8'($urandom_range(255));
         case (dec_phase)
            PH_PIXELS: begin
               if (!dec_run_pending && roll >= 8) begin
                  if (roll < 35) begin
                     len = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                    : 6'($urandom_range(6));
                     b   = RUN_TAG | {2'b00, len};
                  end else begin
                     b = 8'($urandom_range(191));
                  end
               end
            end
            PH_MARKER:  if (roll < 50) b = PALETTE_MARKER;
            PH_PALETTE: if (roll >= 85) sof = 1'b1;
            default:    if (roll >= 10) sof = 1'b1;
         endcase
         if (sof || dec_phase != PH_DONE) counted++;
         push_byte(b, sof);
      end
   endtask

   task automatic test_random_traffic();
      int unsigned      mode;
      int unsigned      roll;
      logic [CSR_W-1:0] w;
      logic [CSR_W-1:0] h;
      for (mode = 0; mode < 4; mode++) begin
         case (mode)
            0: set_pressure(0, 0);
            1: set_pressure(61, 0);
            2: set_pressure(0, 61);
            default: set_pressure(16, 16);
         endcase
         roll = $urandom_range(9);
         w = (roll == 0) ? 10'd0 : (roll == 1) ? 10'($urandom_range(641, 1023))
                                               : 10'($urandom_range(1, 12));
         h = {1'($urandom_range(1)), 9'($urandom_range(0, 4))};
         write_dims(w, h);
         random_stream(27);
         drain_results();
      end
   endtask

   initial begin
      set_pressure(0, 0);
      restart_image();
      cfg_width  = 1;
      cfg_height = 1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_power_on_dims();
      test_directed_bytes();
      test_dim_clamping();
      test_full_frame();
      test_random_traffic();

      set_pressure(0, 0);
      drain_results();
      $display("covered %0d input bytes: %0d pixels and %0d palette bytes checked",
               bytes_sent, pixels_seen, palette_seen);
      $display("a 640-wide row, a 24-row narrow image, clamped sizes, four idle mixes");
      if (fail_count == 0) begin
         $display("pcx_rle_image_decoder regression: pass");
      end else begin
         $display("pcx_rle_image_decoder regression: fail");
      end
      $finish;
   end

endmodule
